@@ hw/rtl/velocity_components_top_assert.svh @@
// Assertion macros shared by the velocity_components checkers.
// Expects signals named clk and rst in the scope of each use.
`ifndef VELOCITY_COMPONENTS_TOP_ASSERT_SVH
`define VELOCITY_COMPONENTS_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define VC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define VC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/vc_pkg.sv @@
// Shared types and constants for the velocity_components block.
// No dependencies; used by every RTL module of the block.
`default_nettype none

package vc_pkg;

  localparam int VALUE_WIDTH_DEF = 24;
  localparam int ITERATIONS_DEF  = 16;
  localparam int ANGLE_WIDTH     = 16;
  localparam int GUARD_BITS      = 8;
  localparam int Z_WIDTH         = 33;

  // Angle in 1/64 degree
  localparam int UNITS_PER_DEG   = 64;
  localparam int HALF_TURN_UNITS = 180 * UNITS_PER_DEG;
  localparam int FULL_TURN       = 2 * HALF_TURN_UNITS;
  localparam int QUARTER_TURN    = FULL_TURN / 4;
  localparam int TURN_WIDTH      = $clog2(FULL_TURN);
  localparam int R_WIDTH         = $clog2(QUARTER_TURN);

  // Degrees to radians: z = r*A + floor((r*B + half) / HALF_TURN_UNITS)
  localparam longint PI_Q30        = 64'sd3373259426;
  localparam longint PI_STEP_INT   = PI_Q30 / HALF_TURN_UNITS;
  localparam longint PI_STEP_FRAC  = PI_Q30 % HALF_TURN_UNITS;
  localparam int     FRAC_SHIFT    = 8;
  localparam longint RECIP_DIV     = HALF_TURN_UNITS / (2 ** FRAC_SHIFT);
  localparam int     RECIP_SHIFT   = 24;
  localparam longint RECIP         = ((64'sd1 << RECIP_SHIFT) + RECIP_DIV - 1) / RECIP_DIV;

  // CORDIC gain compensation, Q24, split in two halves for the multipliers
  localparam longint GAIN_Q24   = 64'sd10188014;
  localparam int     GAIN_SPLIT = 12;
  localparam longint GAIN_HI    = GAIN_Q24 >> GAIN_SPLIT;
  localparam longint GAIN_LO    = GAIN_Q24 % (64'sd1 << GAIN_SPLIT);
  localparam int     GAIN_SHIFT = 24 - GUARD_BITS;

  // atan(2^-i), radians, Q30
  localparam logic [31:0] ATAN_Q30 [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001, 32'h00000000
  };

  typedef enum logic [1:0] {
    QUAD_0   = 2'd0,
    QUAD_90  = 2'd1,
    QUAD_180 = 2'd2,
    QUAD_270 = 2'd3
  } quad_t;

  // Control that travels alongside each transaction in the pipeline
  typedef struct packed {
    logic  valid;
    quad_t quad;
  } ctl_t;

endpackage

`default_nettype wire

@@ hw/rtl/vc_front.sv @@
// Front end: angle reduction to quadrant + residual, degree-to-radian scaling,
// and gain compensation of the speed. Five registered stages. Uses vc_pkg.
`default_nettype none

module vc_front #(
  parameter int VALUE_WIDTH = vc_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          en,
  input  logic                                          in_valid,
  input  logic signed [VALUE_WIDTH-1:0]                 velocity,
  input  logic signed [vc_pkg::ANGLE_WIDTH-1:0]         angle_deg,
  output vc_pkg::ctl_t                                  ctl,
  output logic signed [VALUE_WIDTH+vc_pkg::GUARD_BITS+1:0] x0,
  output logic signed [vc_pkg::Z_WIDTH-1:0]             z0
);
  import vc_pkg::*;

  localparam int XW  = VALUE_WIDTH + GUARD_BITS + 2;
  localparam int PW  = VALUE_WIDTH + GAIN_SPLIT + 1;
  localparam int SW  = XW + GAIN_SHIFT;
  localparam int AW  = ANGLE_WIDTH + 2;
  localparam int P1W = Z_WIDTH - 2;
  localparam int TW  = 26;
  localparam int UW  = TW - FRAC_SHIFT;
  localparam int QW  = UW + 19;
  localparam int FW  = QW - RECIP_SHIFT;

  localparam logic signed [AW-1:0] FULL_S = AW'(FULL_TURN);
  localparam logic [TURN_WIDTH-1:0] T90  = TURN_WIDTH'(QUARTER_TURN);
  localparam logic [TURN_WIDTH-1:0] T180 = TURN_WIDTH'(2 * QUARTER_TURN);
  localparam logic [TURN_WIDTH-1:0] T270 = TURN_WIDTH'(3 * QUARTER_TURN);
  localparam logic [GAIN_SPLIT-1:0] G_HI = GAIN_SPLIT'(GAIN_HI);
  localparam logic [GAIN_SPLIT-1:0] G_LO = GAIN_SPLIT'(GAIN_LO);

  // stage 1: angle modulo one turn
  logic                          v1;
  logic signed [VALUE_WIDTH-1:0] vel1;
  logic [TURN_WIDTH-1:0]         m1;
  logic signed [AW-1:0]          ang_ext, m_full;

  assign ang_ext = angle_deg;

  always_comb begin
    priority if (ang_ext < -FULL_S) begin
      m_full = ang_ext + FULL_S + FULL_S;
    end else if (ang_ext < 0) begin
      m_full = ang_ext + FULL_S;
    end else if (ang_ext >= FULL_S) begin
      m_full = ang_ext - FULL_S;
    end else begin
      m_full = ang_ext;
    end
  end

  // stage 2: quadrant and residual
  logic                          v2;
  logic signed [VALUE_WIDTH-1:0] vel2;
  quad_t                         q2, quad_next;
  logic [R_WIDTH-1:0]            r2;
  logic [TURN_WIDTH-1:0]         diff;

  always_comb begin
    priority if (m1 >= T270) begin
      quad_next = QUAD_270;
      diff      = m1 - T270;
    end else if (m1 >= T180) begin
      quad_next = QUAD_180;
      diff      = m1 - T180;
    end else if (m1 >= T90) begin
      quad_next = QUAD_90;
      diff      = m1 - T90;
    end else begin
      quad_next = QUAD_0;
      diff      = m1;
    end
  end

  // stage 3: integer and fractional parts of the radian scaling, gain halves
  logic                 v3;
  quad_t                q3;
  logic [P1W-1:0]       p1_3;
  logic [UW-1:0]        u3;
  logic signed [PW-1:0] ph3, pl3;
  logic [TW-1:0]        t_next;

  assign t_next = TW'(r2) * TW'(PI_STEP_FRAC) + TW'(HALF_TURN_UNITS / 2);

  // stage 4: reciprocal multiply for the small quotient, gain sum and rounding
  logic                 v4;
  quad_t                q4;
  logic [P1W-1:0]       p1_4;
  logic [FW-1:0]        f4;
  logic signed [XW-1:0] x4;
  logic [QW-1:0]        recip_prod;
  logic signed [SW-1:0] ph_ext, pl_ext, xsum;

  assign recip_prod = QW'(u3) * QW'(RECIP);
  assign ph_ext     = ph3;
  assign pl_ext     = pl3;
  assign xsum       = (ph_ext <<< GAIN_SPLIT) + pl_ext + SW'(2 ** (GAIN_SHIFT - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      ctl.valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      ctl.valid <= v4;
      ctl.quad  <= q4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vel1     <= velocity;
      m1       <= m_full[TURN_WIDTH-1:0];
      vel2     <= vel1;
      q2       <= quad_next;
      r2       <= diff[R_WIDTH-1:0];
      q3       <= q2;
      p1_3     <= P1W'(r2) * P1W'(PI_STEP_INT);
      u3       <= t_next[TW-1:FRAC_SHIFT];
      ph3      <= vel2 * $signed({1'b0, G_HI});
      pl3      <= vel2 * $signed({1'b0, G_LO});
      q4       <= q3;
      p1_4     <= p1_3;
      f4       <= recip_prod[QW-1:RECIP_SHIFT];
      x4       <= xsum[SW-1:GAIN_SHIFT];
      x0       <= x4;
      z0       <= $signed({2'b00, p1_4} + Z_WIDTH'(f4));
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/vc_cordic_cell.sv @@
// One CORDIC rotation cell: a fixed shift and one arctangent constant.
// Registered outputs feed the next cell. Uses vc_pkg.
`default_nettype none

module vc_cordic_cell #(
  parameter int VALUE_WIDTH = vc_pkg::VALUE_WIDTH_DEF,
  parameter int STAGE       = 0
) (
  input  logic                                             clk,
  input  logic                                             rst,
  input  logic                                             en,
  input  vc_pkg::ctl_t                                     ctl_i,
  input  logic signed [VALUE_WIDTH+vc_pkg::GUARD_BITS+1:0] x_i,
  input  logic signed [VALUE_WIDTH+vc_pkg::GUARD_BITS+1:0] y_i,
  input  logic signed [vc_pkg::Z_WIDTH-1:0]                z_i,
  output vc_pkg::ctl_t                                     ctl_o,
  output logic signed [VALUE_WIDTH+vc_pkg::GUARD_BITS+1:0] x_o,
  output logic signed [VALUE_WIDTH+vc_pkg::GUARD_BITS+1:0] y_o,
  output logic signed [vc_pkg::Z_WIDTH-1:0]                z_o
);
  import vc_pkg::*;

  localparam int XW = VALUE_WIDTH + GUARD_BITS + 2;
  localparam logic signed [Z_WIDTH-1:0] ATAN_Z = $signed({1'b0, ATAN_Q30[STAGE]});

  logic signed [XW-1:0]      xs, ys, x_next, y_next;
  logic signed [Z_WIDTH-1:0] z_next;

  // arithmetic shift = floor toward minus infinity
  assign xs = x_i >>> STAGE;
  assign ys = y_i >>> STAGE;

  always_comb begin
    if (!z_i[Z_WIDTH-1]) begin
      x_next = x_i - ys;
      y_next = y_i + xs;
      z_next = z_i - ATAN_Z;
    end else begin
      x_next = x_i + ys;
      y_next = y_i - xs;
      z_next = z_i + ATAN_Z;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_o.valid <= 1'b0;
    end else if (en) begin
      ctl_o.valid <= ctl_i.valid;
      ctl_o.quad  <= ctl_i.quad;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_o        <= x_next;
      y_o        <= y_next;
      z_o        <= z_next;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/velocity_components_top.sv @@
// velocity_components_top: fully pipelined polar-to-rectangular converter.
// Each transaction carries a signed speed (Q15.8) and an angle in 1/64 degree;
// the block returns vx = speed*cos(angle) and vy = speed*sin(angle), Q15.8,
// rounded half up and saturated to VALUE_WIDTH bits. A new transaction can be
// accepted every clock cycle while in_ready is high. From input acceptance to
// out_valid a transaction passes five front-end stages (angle reduction, radian
// scaling, gain compensation), one CORDIC cell per iteration, one quadrant
// stage and the output register. Both in_ready and the output are registered;
// a one-entry skid register behind the output lets the pipeline keep running
// for one transaction after out_ready drops, then in_ready falls until the
// downstream side takes a result. Depends on vc_pkg, vc_front, vc_cordic_cell.
`default_nettype none

module velocity_components_top #(
  parameter int VALUE_WIDTH = vc_pkg::VALUE_WIDTH_DEF,
  parameter int ITERATIONS  = vc_pkg::ITERATIONS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [VALUE_WIDTH-1:0]         velocity,
  input  logic signed [vc_pkg::ANGLE_WIDTH-1:0] angle_deg,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [VALUE_WIDTH-1:0]         vx,
  output logic signed [VALUE_WIDTH-1:0]         vy
);
  import vc_pkg::*;

  localparam int XW = VALUE_WIDTH + GUARD_BITS + 2;

  // Saturation bounds expressed at the internal width
  localparam logic signed [XW-1:0] SAT_HI =
    $signed({{(XW - VALUE_WIDTH + 1){1'b0}}, {(VALUE_WIDTH - 1){1'b1}}});
  localparam logic signed [XW-1:0] SAT_LO = ~SAT_HI;
  localparam logic signed [XW-1:0] RND    = XW'(2 ** (GUARD_BITS - 1));

  logic en;
  logic skid_v;

  // whole pipeline advances unless the skid register is occupied
  assign en       = !skid_v;
  assign in_ready = !skid_v;

  // ---------------------------------------------------------------- front end
  ctl_t                      cs [ITERATIONS+1];
  logic signed [XW-1:0]      xs [ITERATIONS+1];
  logic signed [XW-1:0]      ys [ITERATIONS+1];
  logic signed [Z_WIDTH-1:0] zs [ITERATIONS+1];

  vc_front #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .velocity  (velocity),
    .angle_deg (angle_deg),
    .ctl       (cs[0]),
    .x0        (xs[0]),
    .z0        (zs[0])
  );

  assign ys[0] = '0;

  // ------------------------------------------------------ chain of CORDIC cells
  for (genvar i = 0; i < ITERATIONS; i++) begin : g_cell
    vc_cordic_cell #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .STAGE       (i)
    ) u_cell (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .ctl_i (cs[i]),
      .x_i   (xs[i]),
      .y_i   (ys[i]),
      .z_i   (zs[i]),
      .ctl_o (cs[i+1]),
      .x_o   (xs[i+1]),
      .y_o   (ys[i+1]),
      .z_o   (zs[i+1])
    );
  end

  // -------------------------------------------------- quadrant swap / negate
  logic                 qv;
  logic signed [XW-1:0] cx, cy, cx_next, cy_next;

  always_comb begin
    unique case (cs[ITERATIONS].quad)
      QUAD_0: begin
        cx_next = xs[ITERATIONS];
        cy_next = ys[ITERATIONS];
      end
      QUAD_90: begin
        cx_next = -ys[ITERATIONS];
        cy_next = xs[ITERATIONS];
      end
      QUAD_180: begin
        cx_next = -xs[ITERATIONS];
        cy_next = -ys[ITERATIONS];
      end
      QUAD_270: begin
        cx_next = ys[ITERATIONS];
        cy_next = -xs[ITERATIONS];
      end
      default: begin
        cx_next = xs[ITERATIONS];
        cy_next = ys[ITERATIONS];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      qv <= 1'b0;
    end else if (en) begin
      qv <= cs[ITERATIONS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx <= cx_next;
      cy <= cy_next;
    end
  end

  // ------------------------------------------- round half up, then saturate
  logic signed [XW-1:0]          rx_sh, ry_sh;
  logic signed [VALUE_WIDTH-1:0] rx, ry;

  assign rx_sh = (cx + RND) >>> GUARD_BITS;
  assign ry_sh = (cy + RND) >>> GUARD_BITS;

  always_comb begin
    priority if (rx_sh > SAT_HI) begin
      rx = SAT_HI[VALUE_WIDTH-1:0];
    end else if (rx_sh < SAT_LO) begin
      rx = SAT_LO[VALUE_WIDTH-1:0];
    end else begin
      rx = rx_sh[VALUE_WIDTH-1:0];
    end
  end

  always_comb begin
    priority if (ry_sh > SAT_HI) begin
      ry = SAT_HI[VALUE_WIDTH-1:0];
    end else if (ry_sh < SAT_LO) begin
      ry = SAT_LO[VALUE_WIDTH-1:0];
    end else begin
      ry = ry_sh[VALUE_WIDTH-1:0];
    end
  end

  // ------------------------------------------- output register + skid entry
  logic                          load_out, load_skid, out_valid_next, skid_v_next;
  logic signed [VALUE_WIDTH-1:0] skid_x, skid_y;

  // output loads from skid when it drains, else straight from the pipeline
  assign load_out  = skid_v ? out_ready : (qv && (!out_valid || out_ready));
  assign load_skid = !skid_v && qv && out_valid && !out_ready;

  always_comb begin
    out_valid_next = out_valid;
    if (load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_comb begin
    skid_v_next = skid_v;
    if (load_skid) begin
      skid_v_next = 1'b1;
    end else if (skid_v && out_ready) begin
      skid_v_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_v    <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
      skid_v    <= skid_v_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      vx <= skid_v ? skid_x : rx;
      vy <= skid_v ? skid_y : ry;
    end
    if (load_skid) begin
      skid_x <= rx;
      skid_y <= ry;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/velocity_components_chk.sv @@
// Port-level checker for velocity_components_top, attached with bind.
// Depends on velocity_components_top_assert.svh for the assertion macros.
`default_nettype none

`include "velocity_components_top_assert.svh"

module velocity_components_chk #(
  parameter int VALUE_WIDTH = vc_pkg::VALUE_WIDTH_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [VALUE_WIDTH-1:0] vx,
  input logic signed [VALUE_WIDTH-1:0] vy
);

  // stalled result holds
  `VC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(vx) && $stable(vy), "stalled result changed")

  // back-pressure to the input only while a result sits at the output
  `VC_ASSERT_SAME(a_stall_has_out, !in_ready, out_valid, "in_ready low with no result pending")

  // the skid entry fills only on a stalled output
  `VC_ASSERT_SAME(a_stall_cause, $fell(in_ready), $past(out_valid && !out_ready), "in_ready fell without an output stall")

  // one taken result frees the input again
  `VC_ASSERT_NEXT(a_stall_release, !in_ready && out_ready, in_ready, "in_ready stayed low after a result was taken")

endmodule

bind velocity_components_top velocity_components_chk #(
  .VALUE_WIDTH (VALUE_WIDTH)
) u_chk (.*);

`default_nettype wire

@@ sim/velocity_components_top_tb.sv @@
// Self-checking testbench for velocity_components_top (polar to rectangular).
// Holds its own fixed-point CORDIC predictor; needs only the RTL and vc_pkg.
`timescale 1ns / 100ps

module velocity_components_top_tb;
  import vc_pkg::*;

  localparam int VW              = 24;
  localparam int AW              = vc_pkg::ANGLE_WIDTH;
  localparam int ITER            = 16;
  localparam int RANDOM_PER_PHASE = 470;
  localparam int WATCHDOG_LIMIT  = 4000;   // cycles with no transaction on either side
  localparam int DRAIN_CYCLES    = ITER + 16;

  // Angle in 1/64 degree
  localparam longint TURN_UNITS    = 360 * 64;
  localparam longint QTR_UNITS     = TURN_UNITS / 4;
  localparam longint HALF_UNITS    = TURN_UNITS / 2;
  localparam longint PI_Q30_TB     = 64'sd3373259426;
  localparam longint GAIN_Q24_TB   = 64'sd10188014;   // 1/K of the CORDIC, Q24
  localparam int     GUARD         = 8;
  localparam longint RESULT_MAX    = (64'sd1 <<< (VW - 1)) - 1;
  localparam longint RESULT_MIN    = -(64'sd1 <<< (VW - 1));

  localparam logic signed [VW-1:0] VEL_MAX = 24'sh7FFFFF;
  localparam logic signed [VW-1:0] VEL_MIN = 24'sh800000;

  // atan(2^-i) in radians, Q30, truncated
  localparam logic [31:0] ARCTAN_Q30 [ITER] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
    32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
    32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF
  };

  // One expected result, with the inputs kept for reporting
  typedef struct {
    logic signed [VW-1:0] vel;
    logic signed [AW-1:0] ang;
    logic signed [VW-1:0] vx;
    logic signed [VW-1:0] vy;
  } components_t;

  // Directed stimulus row; known rows carry a hand-typed answer
  typedef struct packed {
    logic signed [VW-1:0] vel;
    logic signed [AW-1:0] ang;
    logic                 known;
    logic signed [VW-1:0] vx;
    logic signed [VW-1:0] vy;
  } vector_row_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  logic signed [VW-1:0] velocity  = '0;
  logic signed [AW-1:0] angle_deg = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic signed [VW-1:0] vx;
  logic signed [VW-1:0] vy;

  components_t pending_components [$];
  int          err_count       = 0;
  int          sent_count      = 0;
  int          checked_count   = 0;
  int          send_idle_pct   = 0;
  int          recv_stall_pct  = 0;
  int          quiet_cycles    = 0;

  velocity_components_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .velocity  (velocity),
    .angle_deg (angle_deg),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .vx        (vx),
    .vy        (vy)
  );

  // 50 MHz
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Round half up out of the guard bits, then clamp to the output range
  function automatic logic signed [VW-1:0] round_clamp(input longint v);
    longint r;
    r = (v + (64'sd1 <<< (GUARD - 1))) >>> GUARD;
    if (r > RESULT_MAX) r = RESULT_MAX;
    if (r < RESULT_MIN) r = RESULT_MIN;
    return r[VW-1:0];
  endfunction

  // Predicts (speed*cos, speed*sin) the way the hardware does it:
  // reduce the angle to one turn, split off the quadrant, rotate the
  // residual with a gain-compensated CORDIC, then swap/negate per quadrant.
  function automatic components_t rotate_velocity(input logic signed [VW-1:0] vel,
                                                  input logic signed [AW-1:0] ang);
    longint      m, r, z, x, y, xn, yn, cx, cy;
    quad_t       quad;
    components_t res;
    m = longint'(ang) % TURN_UNITS;
    if (m < 0) m += TURN_UNITS;
    quad = quad_t'(m / QTR_UNITS);
    r    = m % QTR_UNITS;
    // residual to radians, Q30, rounded
    z = (r * PI_Q30_TB + HALF_UNITS / 2) / HALF_UNITS;
    // pre-scale by 1/K, keep GUARD extra fraction bits
    x = (longint'(vel) * GAIN_Q24_TB + (64'sd1 <<< (23 - GUARD))) >>> (24 - GUARD);
    y = 0;
    for (int i = 0; i < ITER; i++) begin
      if (z >= 0) begin
        xn = x - (y >>> i);
        yn = y + (x >>> i);
        z  = z - longint'(ARCTAN_Q30[i]);
      end else begin
        xn = x + (y >>> i);
        yn = y - (x >>> i);
        z  = z + longint'(ARCTAN_Q30[i]);
      end
      x = xn;
      y = yn;
    end
    case (quad)
      QUAD_0:   begin cx = x;  cy = y;  end
      QUAD_90:  begin cx = -y; cy = x;  end
      QUAD_180: begin cx = -x; cy = -y; end
      default:  begin cx = y;  cy = -x; end
    endcase
    res.vel = vel;
    res.ang = ang;
    res.vx  = round_clamp(cx);
    res.vy  = round_clamp(cy);
    return res;
  endfunction

  // Present one transaction, hold it until in_ready, record the expectation
  // at the accepting edge. Optional idle cycles go in front of it.
  task automatic drive_vector(input logic signed [VW-1:0] vel,
                              input logic signed [AW-1:0] ang,
                              input components_t          exp_c);
    while (int'($urandom_range(0, 99)) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    velocity  <= vel;
    angle_deg <= ang;
    do @(posedge clk); while (!in_ready);
    pending_components.push_back(exp_c);
    sent_count++;
  endtask

  // Output side: random back-pressure and the scoreboard check.
  // Signals are read right after the edge, i.e. their pre-edge values.
  always @(posedge clk) begin : result_check
    components_t exp_c;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        checked_count++;
        if (pending_components.size() == 0) begin
          err_count++;
          $display("%0t: unexpected result vx=%0d vy=%0d", $time, vx, vy);
        end else begin
          exp_c = pending_components.pop_front();
          if (vx !== exp_c.vx) begin
            err_count++;
            $display("%0t: vx mismatch (vel=%0d ang=%0d) expected %0d, actual %0d",
                     $time, exp_c.vel, exp_c.ang, exp_c.vx, vx);
          end
          if (vy !== exp_c.vy) begin
            err_count++;
            $display("%0t: vy mismatch (vel=%0d ang=%0d) expected %0d, actual %0d",
                     $time, exp_c.vel, exp_c.ang, exp_c.vy, vy);
          end
        end
      end
      out_ready <= (int'($urandom_range(0, 99)) >= recv_stall_pct);
    end
  end

  // Watchdog: too long without a transaction on either channel means a hang
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired, %0d results outstanding", $time,
                 pending_components.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin : stimulus
    vector_row_t          rows [22];
    components_t          exp_c;
    logic signed [VW-1:0] vel;
    logic signed [AW-1:0] ang;
    int                   tmp;

    // Zero speed rows are exact; the rest come from the predictor.
    // Covers full-scale speeds on each axis, the +/-360 degree limits,
    // the wraparound beyond a half turn, and the full-scale negative
    // speed at 180 degrees that must clamp to the positive limit.
    rows = '{
      '{24'sd0,     16'sd0,      1'b1, 24'sd0, 24'sd0},
      '{24'sd0,     16'sd23040,  1'b1, 24'sd0, 24'sd0},
      '{24'sd0,    -16'sd23040,  1'b1, 24'sd0, 24'sd0},
      '{VEL_MAX,    16'sd0,      1'b0, 24'sd0, 24'sd0},
      '{VEL_MIN,    16'sd0,      1'b0, 24'sd0, 24'sd0},
      '{VEL_MAX,    16'sd5760,   1'b0, 24'sd0, 24'sd0},
      '{VEL_MAX,    16'sd11520,  1'b0, 24'sd0, 24'sd0},
      '{VEL_MIN,    16'sd11520,  1'b0, 24'sd0, 24'sd0},
      '{VEL_MAX,    16'sd17280,  1'b0, 24'sd0, 24'sd0},
      '{VEL_MIN,    16'sd23040,  1'b0, 24'sd0, 24'sd0},
      '{VEL_MAX,   -16'sd23040,  1'b0, 24'sd0, 24'sd0},
      '{VEL_MAX,   -16'sd5760,   1'b0, 24'sd0, 24'sd0},
      '{24'sd256,   16'sd2880,   1'b0, 24'sd0, 24'sd0},
      '{-24'sd256,  16'sd5759,   1'b0, 24'sd0, 24'sd0},
      '{24'sd1,     16'sd1,      1'b0, 24'sd0, 24'sd0},
      '{-24'sd1,   -16'sd1,      1'b0, 24'sd0, 24'sd0},
      '{VEL_MIN,    16'sd5760,   1'b0, 24'sd0, 24'sd0},
      '{VEL_MIN,   -16'sd17280,  1'b0, 24'sd0, 24'sd0},
      '{24'sh123456, 16'sd22999, 1'b0, 24'sd0, 24'sd0},
      '{-24'sh5A5A5A, -16'sd12345, 1'b0, 24'sd0, 24'sd0},
      '{24'sh7FFF00, 16'sd7680,  1'b0, 24'sd0, 24'sd0},
      '{24'sd1000,  16'sd23039,  1'b0, 24'sd0, 24'sd0}
    };

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed part, back to back with no idling
    foreach (rows[i]) begin
      exp_c = rotate_velocity(rows[i].vel, rows[i].ang);
      if (rows[i].known) begin
        exp_c.vx = rows[i].vx;
        exp_c.vy = rows[i].vy;
      end
      drive_vector(rows[i].vel, rows[i].ang, exp_c);
    end

    // Random part in four handshake phases: free running, sparse sender,
    // heavy back-pressure, then light gaps on both sides
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 63; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 63; end
        default: begin send_idle_pct = 9;  recv_stall_pct = 9;  end
      endcase
      for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
        // speed: mostly full range, some near zero, some at the rails
        case ($urandom_range(0, 9))
          0: begin
            case ($urandom_range(0, 4))
              0:       vel = VEL_MAX;
              1:       vel = VEL_MIN;
              2:       vel = 24'sd1;
              3:       vel = -24'sd1;
              default: vel = 24'sd0;
            endcase
          end
          1, 2: begin
            tmp = int'($urandom_range(0, 2048)) - 1024;
            vel = tmp[VW-1:0];
          end
          default: vel = VW'($urandom());
        endcase
        // angle: quadrant boundaries get extra weight
        if ($urandom_range(0, 9) < 3) begin
          tmp = (int'($urandom_range(0, 8)) - 4) * int'(QTR_UNITS)
                + int'($urandom_range(0, 6)) - 3;
          if (tmp > int'(TURN_UNITS))  tmp = int'(TURN_UNITS);
          if (tmp < -int'(TURN_UNITS)) tmp = -int'(TURN_UNITS);
        end else begin
          tmp = int'($urandom_range(0, 2 * int'(TURN_UNITS))) - int'(TURN_UNITS);
        end
        ang = tmp[AW-1:0];
        drive_vector(vel, ang, rotate_velocity(vel, ang));
      end
    end
    in_valid <= 1'b0;

    // Drain, then give a stray extra result time to show up
    while (pending_components.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d transactions (directed rows plus random), %0d results checked,",
             sent_count, checked_count);
    $display("across free-running, sender-idle, receiver-stall and mixed-gap phases.");
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
